### src/assert_macros.svh
// Assertion macros used by the list engine controller.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### src/ple_pkg.sv
// Shared types and constants of the positional list engine.
// No dependencies.
package ple_pkg;
  localparam int Capacity = 16;
  localparam int ValueWidth = 32;
  localparam int LenWidth = $clog2(Capacity + 1);
  localparam int IdxWidth = $clog2(Capacity);

  typedef enum logic [2:0] {
    K_INS_HEAD = 3'd0, K_INS_TAIL = 3'd1, K_INS_POS = 3'd2, K_UPDATE = 3'd3,
    K_DEL_HEAD = 3'd4, K_DEL_TAIL = 3'd5, K_DEL_POS = 3'd6, K_DUMP = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2, ST_RANGE = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                ins;
    logic                del;
    logic                upd;
    logic [IdxWidth-1:0] pos;
    logic                dump_load;
    logic                dump_shift;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [LenWidth-1:0] length;
  } dp_stat_t;
endpackage

### src/ple_datapath.sv
// Datapath of the list engine: a chain of entry cells and the length count.
// Depends on ple_pkg.
module ple_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  ple_pkg::dp_cmd_t                cmd,
  input  logic signed [ple_pkg::ValueWidth-1:0] item_value,
  output ple_pkg::dp_stat_t               stat,
  output logic signed [ple_pkg::ValueWidth-1:0] head_value
);
  import ple_pkg::*;

  logic [ValueWidth-1:0] entries [Capacity];
  logic [ValueWidth-1:0] dump_q  [Capacity];
  logic [LenWidth-1:0]   length;

  always_ff @(posedge clk) begin
    for (int i = 0; i < Capacity; i++) begin
      if (cmd.ins) begin
        if (i[IdxWidth-1:0] == cmd.pos) entries[i] <= item_value;
        else if (i[IdxWidth-1:0] > cmd.pos && i > 0) entries[i] <= entries[(i > 0) ? i-1 : 0];
      end else if (cmd.del) begin
        if (i[IdxWidth-1:0] >= cmd.pos && i < Capacity-1)
          entries[i] <= entries[(i < Capacity-1) ? i+1 : i];
      end else if (cmd.upd) begin
        if (i[IdxWidth-1:0] == cmd.pos) entries[i] <= item_value;
      end
      // Dump copy streams out through index zero.
      if (cmd.dump_load) dump_q[i] <= entries[i];
      else if (cmd.dump_shift && i < Capacity-1)
        dump_q[i] <= dump_q[(i < Capacity-1) ? i+1 : i];
    end
  end

  // Hold the entry leaving the copy for the cycle in which it is reported.
  always_ff @(posedge clk) begin
    if (cmd.dump_shift) head_value <= dump_q[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (cmd.ins) begin
      length <= length + LenWidth'(1);
    end else if (cmd.del) begin
      length <= length - LenWidth'(1);
    end
  end

  assign stat.length = length;
endmodule

### src/ple_ctrl.sv
// Controller of the list engine: checks commands and sequences dumps.
// Depends on ple_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ple_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [2:0]                     kind,
  input  logic [4:0]                     position,
  input  ple_pkg::dp_stat_t              stat,
  output ple_pkg::dp_cmd_t               cmd,
  output logic                           busy,
  output logic                           res_valid,
  output logic                           res_dump,
  output logic [1:0]                     res_status,
  output logic                           res_last
);
  import ple_pkg::*;

  typedef enum logic [1:0] {S_IDLE = 2'b01, S_DUMP = 2'b10} state_t;
  state_t state, state_next;
  logic [LenWidth-1:0] remain;
  logic accept;
  logic [LenWidth-1:0] len;
  status_t st;
  logic [LenWidth-1:0] pos_ext;

  assign len = stat.length;
  assign accept = start && !busy;
  assign busy = (state == S_DUMP);
  assign pos_ext = LenWidth'(position);

  always_comb begin
    cmd = '0;
    st = ST_OK;
    state_next = state;
    if (accept) begin
      case (kind_t'(kind))
        K_INS_HEAD, K_INS_TAIL, K_INS_POS: begin
          if (len >= LenWidth'(Capacity)) st = ST_FULL;
          else if (kind == K_INS_POS && pos_ext > len) st = ST_RANGE;
          else begin
            cmd.ins = 1'b1;
            cmd.pos = (kind == K_INS_HEAD) ? '0 :
                      (kind == K_INS_TAIL) ? len[IdxWidth-1:0] : position[IdxWidth-1:0];
          end
        end
        K_UPDATE, K_DEL_POS: begin
          if (len == '0) st = ST_EMPTY;
          else if (pos_ext >= len) st = ST_RANGE;
          else begin
            cmd.upd = (kind == K_UPDATE);
            cmd.del = (kind == K_DEL_POS);
            cmd.pos = position[IdxWidth-1:0];
          end
        end
        K_DEL_HEAD, K_DEL_TAIL: begin
          if (len == '0) st = ST_EMPTY;
          else begin
            cmd.del = 1'b1;
            cmd.pos = (kind == K_DEL_HEAD) ? '0 : IdxWidth'(len - LenWidth'(1));
          end
        end
        K_DUMP: begin
          if (len == '0) st = ST_EMPTY;
          else begin
            cmd.dump_load = 1'b1;
            state_next = S_DUMP;
          end
        end
        default: st = ST_OK;
      endcase
    end else if (state == S_DUMP) begin
      cmd.dump_shift = 1'b1;
      if (remain == LenWidth'(1)) state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      remain <= '0;
      res_valid <= 1'b0;
      res_dump <= 1'b0;
      res_status <= ST_OK;
      res_last <= 1'b0;
    end else begin
      state <= state_next;
      res_valid <= 1'b0;
      res_dump <= 1'b0;
      res_last <= 1'b0;
      res_status <= ST_OK;
      if (accept && !cmd.dump_load) begin
        res_valid <= 1'b1;
        res_status <= st;
        res_last <= 1'b1;
      end else if (accept) begin
        remain <= len;
      end else if (state == S_DUMP) begin
        // Emit head of the copy and advance.
        res_valid <= 1'b1;
        res_dump <= 1'b1;
        res_last <= (remain == LenWidth'(1));
        remain <= remain - LenWidth'(1);
      end
    end
  end

  `ASSERT_IMPLY(a_onehot, clk, rst, 1'b1, $onehot(state))
  `ASSERT_IMPLY(a_dump_remain, clk, rst, state == S_DUMP, remain != '0)
  `ASSERT_NEXT(a_mut_result, clk, rst, accept && kind != K_DUMP, res_valid && res_last)
endmodule

### src/positional_list_engine_top.sv
// A mutation result is registered from the accepting cycle. A dump first loads
// the copy of the list, then reports one entry per cycle through the head register,
// with busy high until the last entry is shifted out; the next command is taken after.
// Throughput: a mutation every cycle while no dump holds busy high.
// Reset (rst, synchronous) empties the list; stored values are not cleared.
// The receiver cannot stall; each result shows on valid for one cycle.
module positional_list_engine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic signed [31:0] item_value,
  input  logic [4:0]         position,
  output logic               valid,
  output logic signed [31:0] out_value,
  output logic [1:0]         status,
  output logic [4:0]         length_now,
  output logic               last
);
  import ple_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic signed [ValueWidth-1:0] head_value;
  logic res_dump;

  ple_ctrl u_ctrl (
    .clk, .rst, .start, .kind, .position, .stat, .cmd, .busy,
    .res_valid(valid), .res_dump, .res_status(status), .res_last(last)
  );

  ple_datapath u_dp (
    .clk, .rst, .cmd, .item_value, .stat, .head_value
  );

  assign out_value  = res_dump ? head_value : '0;
  assign length_now = 5'(stat.length);
endmodule

### tb/tb.sv
// Self-checking testbench for positional_list_engine_top: directed table, then random commands.
// Depends on ple_pkg and the engine RTL; results are checked against an in-bench list predictor.
module tb;
  import ple_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         kind = '0;
  logic signed [31:0] item_value = '0;
  logic [4:0]         position = '0;
  logic               valid;
  logic signed [31:0] out_value;
  logic [1:0]         status;
  logic [4:0]         length_now;
  logic               last;

  positional_list_engine_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .item_value(item_value), .position(position), .valid(valid),
    .out_value(out_value), .status(status), .length_now(length_now), .last(last)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic signed [31:0] value;
    status_t            st;
    logic [4:0]         len;
    logic               fin;
  } list_result_t;

  typedef struct {
    kind_t              k;
    logic signed [31:0] v;
    logic [4:0]         p;
    bit                 has_want;
    list_result_t       want;
  } cmd_row_t;

  logic signed [31:0] shadow_list [Capacity];
  int                 shadow_len;
  list_result_t       pending_results [$];
  int                 error_count;
  int                 idle_cycles;
  int                 sender_idle_pct;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("tb: mismatch %s at %0t", what, $time);
  endtask

  function automatic list_result_t mk(input logic signed [31:0] v, input status_t s,
                                      input int n, input logic f);
    list_result_t r;
    r.value = v; r.st = s; r.len = n[4:0]; r.fin = f;
    return r;
  endfunction

  // Apply one command to the shadow list and queue the results it yields.
  task automatic predict_list(input kind_t k, input logic signed [31:0] v,
                              input int p);
    status_t s;
    int      at;
    s = ST_OK;
    case (k)
      K_INS_HEAD, K_INS_TAIL, K_INS_POS: begin
        at = (k == K_INS_HEAD) ? 0 : (k == K_INS_TAIL) ? shadow_len : p;
        if (shadow_len >= Capacity) s = ST_FULL;
        else if (at > shadow_len) s = ST_RANGE;
        else begin
          for (int i = shadow_len; i > at; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[at] = v;
          shadow_len++;
        end
      end
      K_UPDATE: begin
        if (shadow_len == 0) s = ST_EMPTY;
        else if (p >= shadow_len) s = ST_RANGE;
        else shadow_list[p] = v;
      end
      K_DEL_HEAD, K_DEL_TAIL, K_DEL_POS: begin
        at = (k == K_DEL_HEAD) ? 0 : (k == K_DEL_TAIL) ? shadow_len - 1 : p;
        if (shadow_len == 0) s = ST_EMPTY;
        else if (at >= shadow_len) s = ST_RANGE;
        else begin
          for (int i = at; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      default: begin
        if (shadow_len == 0) s = ST_EMPTY;
        else begin
          for (int i = 0; i < shadow_len; i++)
            pending_results.push_back(mk(shadow_list[i], ST_OK, shadow_len,
                                         i + 1 == shadow_len));
          return;
        end
      end
    endcase
    pending_results.push_back(mk('0, s, shadow_len, 1'b1));
  endtask

  // Drive one transaction: wait out sender idling and busy; start drops only while idling.
  task automatic send_cmd(input kind_t k, input logic signed [31:0] v, input logic [4:0] p);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    kind <= k; item_value <= v; position <= p; start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_list(k, v, p);
    @(negedge clk);
  endtask

  task automatic send_random();
    int r;
    kind_t k;
    logic signed [31:0] v;
    logic [4:0] p;
    r = $urandom_range(99);
    // Bias toward inserts while short and deletes while long to sweep the fill level.
    if (r < 45) k = kind_t'($urandom_range(shadow_len > 12 ? 4 : 0, shadow_len > 12 ? 6 : 2));
    else if (r < 92) k = kind_t'($urandom_range(0, 6));
    else k = K_DUMP;
    v = $urandom();
    if ($urandom_range(9) == 0) v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    p = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                 : 5'($urandom_range(shadow_len + 1));
    send_cmd(k, v, p);
  endtask

  always @(posedge clk) begin
    list_result_t w;
    if (!rst && valid) begin
      if (pending_results.size() == 0) report_mismatch("unexpected result");
      else begin
        w = pending_results.pop_front();
        if (out_value !== w.value) report_mismatch("out_value");
        if (status !== w.st) report_mismatch("status");
        if (length_now !== w.len) report_mismatch("length_now");
        if (last !== w.fin) report_mismatch("last");
      end
    end
  end

  // Watchdog: count cycles without any transaction.
  always @(posedge clk) begin
    if (rst || valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  cmd_row_t rows [$];

  initial begin
    cmd_row_t row;
    error_count = 0;
    idle_cycles = 0;
    shadow_len = 0;
    sender_idle_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    rows.push_back('{K_DUMP, 0, 0, 1, mk(0, ST_EMPTY, 0, 1)});
    rows.push_back('{K_DEL_HEAD, 0, 0, 1, mk(0, ST_EMPTY, 0, 1)});
    rows.push_back('{K_DEL_TAIL, 0, 0, 1, mk(0, ST_EMPTY, 0, 1)});
    rows.push_back('{K_DEL_POS, 0, 0, 1, mk(0, ST_EMPTY, 0, 1)});
    rows.push_back('{K_UPDATE, 5, 0, 1, mk(0, ST_EMPTY, 0, 1)});
    rows.push_back('{K_INS_POS, 9, 1, 1, mk(0, ST_RANGE, 0, 1)});
    rows.push_back('{K_INS_POS, 32'sh7fffffff, 0, 1, mk(0, ST_OK, 1, 1)});
    rows.push_back('{K_DUMP, 0, 0, 0, mk(0, ST_OK, 0, 0)});
    rows.push_back('{K_DEL_TAIL, 0, 0, 1, mk(0, ST_OK, 0, 1)});
    rows.push_back('{K_INS_TAIL, 32'sh80000000, 0, 1, mk(0, ST_OK, 1, 1)});
    rows.push_back('{K_INS_HEAD, -1, 0, 1, mk(0, ST_OK, 2, 1)});
    rows.push_back('{K_UPDATE, 7, 2, 1, mk(0, ST_RANGE, 2, 1)});
    rows.push_back('{K_UPDATE, 7, 1, 1, mk(0, ST_OK, 2, 1)});
    rows.push_back('{K_DEL_POS, 0, 2, 1, mk(0, ST_RANGE, 2, 1)});
    rows.push_back('{K_DUMP, 0, 0, 0, mk(0, ST_OK, 0, 0)});
    rows.push_back('{K_DEL_HEAD, 0, 0, 1, mk(0, ST_OK, 1, 1)});
    for (int i = 0; i < 15; i++) rows.push_back('{K_INS_POS, i, 5'(i / 2), 0, mk(0, ST_OK, 0, 0)});
    rows.push_back('{K_INS_HEAD, 1, 0, 1, mk(0, ST_FULL, 16, 1)});
    rows.push_back('{K_INS_POS, 1, 31, 1, mk(0, ST_FULL, 16, 1)});
    rows.push_back('{K_DUMP, 0, 0, 0, mk(0, ST_OK, 0, 0)});
    rows.push_back('{K_DEL_POS, 0, 16, 1, mk(0, ST_RANGE, 16, 1)});
    rows.push_back('{K_DEL_POS, 0, 15, 1, mk(0, ST_OK, 15, 1)});
    foreach (rows[i]) begin
      row = rows[i];
      send_cmd(row.k, row.v, row.p);
      // A typed-in expectation must agree with the predictor's own entry.
      if (row.has_want && pending_results[$] !== row.want) report_mismatch("directed row");
    end
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 1) ? 52 : (ph == 3) ? 26 : 0;
      repeat (110) send_random();
    end
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule

### files.f
+incdir+src
src/ple_pkg.sv
src/ple_datapath.sv
src/ple_ctrl.sv
src/positional_list_engine_top.sv
tb/tb.sv
